// File: hdl/fdp_pkg.sv
// Shared constants and types for the framed decimal parameter parser.
package fdp_pkg;

   localparam int DEF_NUM_FIELDS = 7;
   localparam int DEF_VALUE_BITS = 32;

   // Parameters shown on the result channel and their width
   localparam int OUT_PARAMS = 7;
   localparam int PARAM_W    = 32;
   localparam int COUNT_W    = 3;

   // Framing and token characters
   localparam logic [7:0] CH_STX   = 8'h02;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_WS_LO = 8'h09;
   localparam logic [7:0] CH_WS_HI = 8'h0D;

   // Value of a field that was never reached
   localparam logic [PARAM_W-1:0] PARAM_ABSENT = '1;

   // Token phase codes
   localparam logic [1:0] PH_LEAD = 2'd0;  // skipping leading whitespace
   localparam logic [1:0] PH_SIGN = 2'd1;  // sign taken
   localparam logic [1:0] PH_DIG  = 2'd2;  // reading digits
   localparam logic [1:0] PH_STOP = 2'd3;  // token ended, rest ignored

   typedef struct packed {
      logic [OUT_PARAMS-1:0][PARAM_W-1:0] param;
      logic [COUNT_W-1:0]                 field_count;
   } rsp_payload_type;

endpackage

// File: hdl/fdp_channels.sv
// Valid/ready channel interfaces for byte input and parameter results.
interface fdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fdp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] param_a;
   logic signed [31:0] param_b;
   logic signed [31:0] param_c;
   logic signed [31:0] param_d;
   logic signed [31:0] param_e;
   logic signed [31:0] param_f;
   logic signed [31:0] param_g;
   logic [2:0]         field_count;

   modport source (output valid, output param_a, output param_b, output param_c,
                   output param_d, output param_e, output param_f, output param_g,
                   output field_count, input ready);
   modport sink   (input valid, input param_a, input param_b, input param_c,
                   input param_d, input param_e, input param_f, input param_g,
                   input field_count, output ready);
endinterface

// File: hdl/fdp_frame_core.sv
// Frame and token state, byte-wise update and result assembly.
module fdp_frame_core
   import fdp_pkg::*;
#(
   parameter int NUM_FIELDS = DEF_NUM_FIELDS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            beat_valid,
   input  logic [7:0]      rx_byte,
   output logic            res_push,
   output rsp_payload_type res_data
);

   localparam int FI_W = $clog2(NUM_FIELDS + 1);
   localparam int PW   = VALUE_BITS + 4;
   localparam logic [FI_W-1:0]       NF_FI   = FI_W'(NUM_FIELDS);
   localparam logic [COUNT_W-1:0]    NF_CNT  = COUNT_W'(NUM_FIELDS);
   localparam logic [VALUE_BITS-1:0] HALF    = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] MAX_POS = HALF - 1'b1;

   logic                  in_frame_ff, in_frame_in;
   logic [FI_W-1:0]       fi_ff, fi_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [1:0]            phase_ff, phase_in;
   logic [PARAM_W-1:0]    store_ff [NUM_FIELDS];
   logic [PARAM_W-1:0]    store_in [NUM_FIELDS];

   logic                  is_digit, is_ws, is_sign, fi_open;
   logic [PW-1:0]         prod;
   logic [VALUE_BITS-1:0] acc_digit;
   logic [PARAM_W-1:0]    tok_val;

   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign is_ws    = (rx_byte >= CH_WS_LO) && (rx_byte <= CH_WS_HI);
   assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
   assign fi_open  = fi_ff < NF_FI;

   // accum * 10 + digit, clamped to the magnitude of the most negative value
   assign prod      = (PW'(acc_ff) << 3) + (PW'(acc_ff) << 1) + PW'(rx_byte[3:0]);
   assign acc_digit = (prod > PW'(HALF)) ? HALF : prod[VALUE_BITS-1:0];

   always_comb begin
      if (neg_ff) begin
         tok_val = PARAM_W'(0) - PARAM_W'(acc_ff);
      end else if (acc_ff > MAX_POS) begin
         tok_val = PARAM_W'(MAX_POS);
      end else begin
         tok_val = PARAM_W'(acc_ff);
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      fi_in       = fi_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      phase_in    = phase_ff;
      store_in    = store_ff;
      res_push    = 1'b0;
      if (beat_valid) begin
         if (rx_byte == CH_STX) begin
            in_frame_in = 1'b1;
            fi_in       = '0;
            acc_in      = '0;
            neg_in      = 1'b0;
            phase_in    = PH_LEAD;
            for (int e = 0; e < NUM_FIELDS; e++) begin
               store_in[e] = PARAM_ABSENT;
            end
         end else if (in_frame_ff) begin
            if (rx_byte == CH_ETX) begin
               res_push    = 1'b1;
               in_frame_in = 1'b0;
               for (int e = 0; e < NUM_FIELDS; e++) begin
                  if (fi_ff == FI_W'(e)) store_in[e] = tok_val;
               end
            end else if (fi_open) begin
               if (rx_byte == CH_SPACE) begin
                  for (int e = 0; e < NUM_FIELDS; e++) begin
                     if (fi_ff == FI_W'(e)) store_in[e] = tok_val;
                  end
                  fi_in    = fi_ff + 1'b1;
                  acc_in   = '0;
                  neg_in   = 1'b0;
                  phase_in = PH_LEAD;
               end else if (phase_ff != PH_STOP) begin
                  if (phase_ff == PH_LEAD && is_ws) begin
                     phase_in = PH_LEAD;
                  end else if (phase_ff == PH_LEAD && is_sign) begin
                     neg_in   = (rx_byte == CH_MINUS);
                     phase_in = PH_SIGN;
                  end else if (is_digit) begin
                     acc_in   = acc_digit;
                     phase_in = PH_DIG;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
            end
         end
      end
   end

   // Result: the open token bypasses the store on ETX
   generate
      for (genvar k = 0; k < OUT_PARAMS; k++) begin : g_out
         if (k < NUM_FIELDS) begin : g_live
            assign res_data.param[k] =
               (fi_ff == FI_W'(k)) ? tok_val : store_ff[k];
         end else begin : g_absent
            assign res_data.param[k] = PARAM_ABSENT;
         end
      end
   endgenerate

   assign res_data.field_count = fi_open ? COUNT_W'(fi_ff + 1'b1) : NF_CNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fi_ff       <= '0;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         phase_ff    <= PH_LEAD;
      end else begin
         in_frame_ff <= in_frame_in;
         fi_ff       <= fi_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         phase_ff    <= phase_in;
      end
   end

   // Any read of the store is preceded by STX, which fills it
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

// File: hdl/fdp_rsp_buffer.sv
// Result register with a skid stage behind it.
module fdp_rsp_buffer
   import fdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            space,
   output logic            out_valid,
   output rsp_payload_type out_data,
   input  logic            out_ready
);

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            pop;

   assign pop   = out_valid_ff && out_ready;
   assign space = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// File: hdl/framed_decimal_param_parser_top.sv
// Framed decimal parameter parser, top level.
//
// Takes one received byte per beat on req and reads STX/ETX framed ASCII
// commands. STX opens (or restarts) a frame and sets every parameter to -1.
// Inside the frame, space-separated tokens convert like atoi: leading
// 0x09..0x0D skipped, optional +/- sign, digits up to the first non-digit,
// empty token = 0. Magnitudes saturate to the signed VALUE_BITS range and
// are sign-extended to 32 bits. After NUM_FIELDS space-ended fields,
// everything up to ETX is dropped. ETX stores the open token and sends one
// rsp beat: param_a..param_g (fields not reached read -1) and field_count.
// Bytes outside a frame, ETX included, are dropped with no result.
//
// Rate: one byte per clock while req.ready is high. The byte update (accumulate
// x10 plus digit with clamp) sits between the frame state registers and the
// result register; the ETX result is registered there before it shows on rsp.
// A result register plus a one-deep skid stage sit on rsp; req.ready drops
// only while both hold results that rsp has not taken.
module framed_decimal_param_parser_top
   import fdp_pkg::*;
#(
   parameter int NUM_FIELDS = DEF_NUM_FIELDS,  // 1..7
   parameter int VALUE_BITS = DEF_VALUE_BITS   // 8..32
) (
   input  logic      clock,
   input  logic      reset,
   fdp_req_if.sink   req,
   fdp_rsp_if.source rsp
);

   logic            req_beat;
   logic            res_push;
   logic            buf_space;
   rsp_payload_type res_data;
   rsp_payload_type out_data;

   assign req.ready = buf_space;
   assign req_beat  = req.valid && buf_space;

   fdp_frame_core #(
      .NUM_FIELDS (NUM_FIELDS),
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_beat),
      .rx_byte    (req.rx_byte),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   fdp_rsp_buffer u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .space     (buf_space),
      .out_valid (rsp.valid),
      .out_data  (out_data),
      .out_ready (rsp.ready)
   );

   // Fan the result word out onto the named fields
   assign rsp.param_a     = out_data.param[0];
   assign rsp.param_b     = out_data.param[1];
   assign rsp.param_c     = out_data.param[2];
   assign rsp.param_d     = out_data.param[3];
   assign rsp.param_e     = out_data.param[4];
   assign rsp.param_f     = out_data.param[5];
   assign rsp.param_g     = out_data.param[6];
   assign rsp.field_count = out_data.field_count;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the framed decimal parameter parser, directed and random byte streams.
module tb_top
   import fdp_pkg::*;
();

   localparam int          N_FIELDS     = DEF_NUM_FIELDS;
   localparam int          TARGET_BYTES = 1550;
   localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
   localparam logic [63:0] MAG_CAP      = 64'h8000_0000;

   // Receiver stall styles
   typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_LONG} rx_mode_type;

   logic clock;
   logic reset;

   fdp_req_if req_ch ();
   fdp_rsp_if rsp_ch ();

   framed_decimal_param_parser_top dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // ------------------------------------------------------------------
   // Parser shadow state, updated on every accepted req beat
   // ------------------------------------------------------------------
   logic        cmd_open;
   int          field_pos;
   logic [31:0] token_mag;     // magnitude, saturates at 2^31
   logic        token_neg;
   logic [1:0]  token_ph;
   logic [31:0] field_val [N_FIELDS];

   // parameter sets still owed by the block, oldest first
   rsp_payload_type pending_params [$];

   int error_count;
   int result_count;
   int cmd_bytes;     // beats that landed in a frame (STX included)
   int stray_bytes;   // beats dropped outside any frame
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs on either channel
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void clear_token();
      token_mag = '0;
      token_neg = 1'b0;
      token_ph  = PH_LEAD;
   endfunction

   function automatic void clear_frame();
      field_pos = 0;
      clear_token();
      for (int i = 0; i < N_FIELDS; i++) field_val[i] = PARAM_ABSENT;
   endfunction

   // atoi-style value of the open token; negative side needs no clamp
   // since the magnitude already stops at 2^31
   function automatic logic [31:0] token_result();
      if (token_neg) return 32'd0 - token_mag;
      return (token_mag > POS_MAX) ? POS_MAX : token_mag;
   endfunction

   // Advance the shadow parser by one byte; queue a parameter set on ETX
   function automatic void parse_byte(logic [7:0] b);
      rsp_payload_type exp_rsp;
      logic [63:0]     grown;
      if (b == CH_STX) begin
         // STX opens a frame, or restarts one already open
         cmd_open = 1'b1;
         clear_frame();
         cmd_bytes++;
         return;
      end
      if (!cmd_open) begin
         stray_bytes++;
         return;
      end
      cmd_bytes++;
      if (b == CH_ETX) begin
         // open token becomes the last field unless the field limit hit
         if (field_pos < N_FIELDS) begin
            field_val[field_pos] = token_result();
            exp_rsp.field_count  = COUNT_W'(field_pos + 1);
         end else begin
            exp_rsp.field_count = COUNT_W'(N_FIELDS);
         end
         for (int k = 0; k < OUT_PARAMS; k++)
            exp_rsp.param[k] = (k < N_FIELDS) ? field_val[k] : PARAM_ABSENT;
         pending_params.push_back(exp_rsp);
         cmd_open = 1'b0;
         return;
      end
      // all fields closed: everything up to ETX is dropped
      if (field_pos >= N_FIELDS) return;
      if (b == CH_SPACE) begin
         field_val[field_pos] = token_result();
         field_pos++;
         clear_token();
      end else if (token_ph != PH_STOP) begin
         if (token_ph == PH_LEAD && b >= CH_WS_LO && b <= CH_WS_HI) return;
         if (token_ph == PH_LEAD && (b == CH_MINUS || b == CH_PLUS)) begin
            token_neg = (b == CH_MINUS);
            token_ph  = PH_SIGN;
            return;
         end
         if (b >= CH_ZERO && b <= CH_NINE) begin
            grown     = {32'd0, token_mag} * 64'd10 + 64'(b - CH_ZERO);
            token_mag = (grown > MAG_CAP) ? MAG_CAP[31:0] : grown[31:0];
            token_ph  = PH_DIG;
         end else begin
            // first non-digit freezes the token
            token_ph = PH_STOP;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // req driver: bursts of random length, random idle gaps in between.
   // valid stays high across back-to-back beats so it never gets two
   // nonblocking updates in one step.
   // ------------------------------------------------------------------
   task automatic send_byte(logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      parse_byte(b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Hold the sender off until every owed result has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_params.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // rsp sink: ready pattern switches among random styles,
   // including long windows with no stall at all
   // ------------------------------------------------------------------
   initial begin
      rx_mode_type mode;
      int          left;
      int          run;
      logic        hold_lvl;
      logic [7:0]  mask;
      rsp_ch.ready <= 1'b0;
      mode     = RX_FREE;
      left     = 0;
      run      = 0;
      hold_lvl = 1'b1;
      mask     = 8'hFF;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(50, 300);
            mask = 8'($urandom) | 8'h01;
         end
         left--;
         case (mode)
            RX_FREE:    rsp_ch.ready <= 1'b1;
            RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_ch.ready <= mask[left[2:0]];
            default: begin
               // long stalls with short open windows
               if (run == 0) begin
                  hold_lvl = ~hold_lvl;
                  run      = hold_lvl ? $urandom_range(1, 8) : $urandom_range(5, 20);
               end
               run--;
               rsp_ch.ready <= hold_lvl;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // rsp checker: each taken beat against the oldest owed parameter set
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      logic [31:0]     got [OUT_PARAMS];
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.param_a, rsp_ch.param_b, rsp_ch.param_c, rsp_ch.param_d,
                 rsp_ch.param_e, rsp_ch.param_f, rsp_ch.param_g};
         result_count++;
         if (pending_params.size() == 0) begin
            error_count++;
            $display("%0t ERROR: result with none expected, got field_count %0d param_a %0d",
                     $time, rsp_ch.field_count, rsp_ch.param_a);
         end else begin
            want = pending_params.pop_front();
            for (int k = 0; k < OUT_PARAMS; k++) begin
               if (got[k] !== want.param[k]) begin
                  error_count++;
                  $display("%0t ERROR: param_%c expected %0d got %0d", $time, 8'h61 + k,
                           $signed(want.param[k]), $signed(got[k]));
               end
            end
            if (rsp_ch.field_count !== want.field_count) begin
               error_count++;
               $display("%0t ERROR: field_count expected %0d got %0d", $time,
                        want.field_count, rsp_ch.field_count);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // ETX and byte extremes with no frame open: no result allowed
   task automatic test_stray_bytes();
      send_byte(CH_ETX);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // tab before a plus sign, junk 0xFF after the digit, then an empty frame
   task automatic test_token_forms();
      send_byte(CH_STX);
      send_byte(CH_WS_LO);
      send_byte(CH_PLUS);
      send_byte("7");
      send_byte(8'hFF);
      send_byte(CH_ETX);
      send_byte(CH_STX);
      send_byte(CH_ETX);
   endtask

   // seven empty fields close the frame; the trailing digit must be dropped
   task automatic test_field_limit();
      send_byte(CH_STX);
      repeat (N_FIELDS) send_byte(CH_SPACE);
      send_byte("5");
      send_byte(CH_ETX);
   endtask

   // STX inside a frame throws away the partial token; lone minus reads 0
   task automatic test_frame_restart();
      send_byte(CH_STX);
      send_byte("4");
      send_byte(CH_STX);
      send_byte(CH_MINUS);
      send_byte(CH_ETX);
   endtask

   // ------------------------------------------------------------------
   // Random tests
   // ------------------------------------------------------------------

   // One token: optional leading whitespace and sign, then short digits,
   // long overflowing digits or a value at the 32-bit edges, maybe junk
   function automatic string make_token();
      string  s;
      longint bound_val;
      s = "";
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 2))
            s = $sformatf("%s%c", s, 8'($urandom_range(CH_WS_LO, CH_WS_HI)));
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0:       bound_val = 64'sd2147483647;
               1:       bound_val = 64'sd2147483648;
               2:       bound_val = -64'sd2147483648;
               3:       bound_val = -64'sd2147483649;
               4:       bound_val = 64'sd4294967296;
               default: bound_val = 0;
            endcase
            s = $sformatf("%s%0d", s, bound_val);
         end
         1: begin
            if ($urandom_range(0, 1)) s = {s, "-"};
            repeat ($urandom_range(9, 14)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
         end
         default: begin
            case ($urandom_range(0, 5))
               0:       s = {s, "-"};
               1:       s = {s, "+"};
               default: ;
            endcase
            repeat ($urandom_range(0, 5)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
         end
      endcase
      if ($urandom_range(0, 7) == 0) begin
         // trailing byte from 0x04..0xFF; where it is junk it stops the token and digits after it must not count
         s = $sformatf("%s%c", s, 8'($urandom_range(8'h04, 8'hFF)));
         if ($urandom_range(0, 1)) s = $sformatf("%s%0d", s, $urandom_range(0, 99));
      end
      return s;
   endfunction

   // One frame: mostly well-formed tokens, sometimes raw garbage, a stray
   // byte mid-frame, a missing ETX or line noise after the frame
   task automatic random_frame();
      int         ntok;
      logic [7:0] c;
      send_byte(CH_STX);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(3, 20)) begin
            case ($urandom_range(0, 3))
               0:       c = 8'($urandom_range(0, 255));
               1:       c = 8'($urandom_range(CH_ZERO, CH_NINE));
               2:       c = CH_SPACE;
               default: c = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
            endcase
            send_byte(c);
         end
      end else begin
         ntok = $urandom_range(0, 9);
         for (int i = 0; i < ntok; i++) begin
            send_text(make_token());
            if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(0, 255)));
            // double spaces make empty fields
            if (i < ntok - 1 || $urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 3 : 1))
                  send_byte(CH_SPACE);
         end
      end
      if ($urandom_range(0, 14) != 0) send_byte(CH_ETX);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_frames();
      int start_bytes;
      int n_frames;
      start_bytes = cmd_bytes;
      n_frames    = 0;
      while (cmd_bytes - start_bytes < TARGET_BYTES) begin
         random_frame();
         n_frames++;
         // one full pause partway through
         if (n_frames == 40) drain_results();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      reset          <= 1'b1;
      error_count  = 0;
      result_count = 0;
      cmd_bytes    = 0;
      stray_bytes  = 0;
      burst_left   = 0;
      cmd_open     = 1'b0;
      clear_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_stray_bytes();
      test_token_forms();
      test_field_limit();
      test_frame_restart();
      drain_results();
      test_random_frames();

      // all beats in; wait for owed results, then keep watching for strays
      drain_results();
      repeat (10) @(posedge clock);

      $display("Covered %0d in-frame bytes and %0d out-of-frame bytes;", cmd_bytes, stray_bytes);
      $display("checked %0d parameter sets under random gaps and stalls.", result_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
